FILE: hdl/sorted_table_occurrence_count_unit_assert.svh
// assertion macros for the sorted table occurrence counter
`ifndef SORTED_TABLE_OCCURRENCE_COUNT_UNIT_ASSERT_SVH
`define SORTED_TABLE_OCCURRENCE_COUNT_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define STOCC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stocc assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define STOCC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("stocc assertion failed");

`endif

FILE: hdl/stocc_pkg.sv
// shared constants for the sorted table occurrence counter
package stocc_pkg;

  // item field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned OUT_W   = 11;

  // operation codes
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  typedef logic [OP_W-1:0]           op_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [OUT_W-1:0]          out_field_t;

endpackage

FILE: hdl/stocc_req_if.sv
// request channel: operation and value
interface stocc_req_if;
  import stocc_pkg::*;

  logic   valid;
  logic   ready;
  op_t    op;
  value_t value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

FILE: hdl/stocc_rsp_if.sv
// response channel: occurrence count and lower bound
interface stocc_rsp_if;
  import stocc_pkg::*;

  logic       valid;
  logic       ready;
  out_field_t occurrences;
  out_field_t first_position;

  modport source (output valid, output occurrences, output first_position, input ready);
  modport sink (input valid, input occurrences, input first_position, output ready);
endinterface

FILE: hdl/stocc_bound_step.sv
// shared binary search step: midpoint, signed compare and range update
module stocc_bound_step #(
  parameter int unsigned CNT_W  = 11,
  parameter int unsigned ADDR_W = 10
) (
  input  logic [CNT_W-1:0]       lo_i,
  input  logic [CNT_W-1:0]       hi_i,
  input  stocc_pkg::value_t      probe_i,
  input  stocc_pkg::value_t      key_i,
  input  logic                   strict_i,
  output logic                   done_o,
  output logic [ADDR_W-1:0]      mid_o,
  output logic [CNT_W-1:0]       lo_next_o,
  output logic [CNT_W-1:0]       hi_next_o
);
  import stocc_pkg::*;

  logic [CNT_W:0] sum_m1;
  logic [CNT_W:0] mid_wide;
  logic           go_left;

  // range is empty once lo reaches hi
  assign done_o = (lo_i >= hi_i);

  // midpoint of the closed range, rounding down
  assign sum_m1   = {1'b0, lo_i} + {1'b0, hi_i} - {{CNT_W{1'b0}}, 1'b1};
  assign mid_wide = sum_m1 >> 1;
  assign mid_o    = mid_wide[ADDR_W-1:0];

  // lower bound moves left on probe >= key, upper bound on probe > key
  assign go_left = strict_i ? (probe_i > key_i) : (probe_i >= key_i);

  // halve the range
  always_comb begin
    lo_next_o = lo_i;
    hi_next_o = hi_i;
    if (go_left) begin
      hi_next_o = mid_wide[CNT_W-1:0];
    end else begin
      lo_next_o = mid_wide[CNT_W-1:0] + {{(CNT_W-1){1'b0}}, 1'b1};
    end
  end
endmodule

FILE: hdl/sorted_table_occurrence_count_unit.sv
// top level: sorted table store, search sequencer and result register
//
// Keeps up to TABLE_DEPTH signed 32-bit values loaded in ascending order.
// Clear and append are applied when the request is taken; an append to a full table is dropped.
// A query runs a lower-bound and an upper-bound binary search over the filled
// entries and returns the lower bound and the number of entries equal to the
// key. Each probe is a registered read of the table memory followed by the
// compare and range update in the shared step unit, with at most
// ceil(log2(fill + 1)) probes per search. The request side is not ready while
// a query is in flight; a result waiting in the output register does not stop
// clear and append transfers.
module sorted_table_occurrence_count_unit #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input logic         clk_i,
  input logic         rst_ni,
  stocc_req_if.sink   req_i,
  stocc_rsp_if.source rsp_o
);
  import stocc_pkg::*;

  localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PROBE = 2'd1;
  localparam logic [1:0] S_CMP   = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] lo_q, lo_d;
  logic [CNT_W-1:0] hi_q, hi_d;
  logic [CNT_W-1:0] lower_q, lower_d;
  logic             strict_q, strict_d;
  value_t           key_q, key_d;
  value_t           rdata_q;
  logic             rsp_valid_q, rsp_valid_d;
  out_field_t       occ_q, occ_d;
  out_field_t       first_q, first_d;

  logic             req_xfer;
  logic             wr_en;
  logic             rd_en;
  logic             step_done;
  logic [ADDR_W-1:0] step_mid;
  logic [CNT_W-1:0] step_lo;
  logic [CNT_W-1:0] step_hi;
  logic [CNT_W-1:0] count;

  value_t table_mem [TABLE_DEPTH];

  // handshake
  assign req_i.ready = (state_q == S_IDLE);
  assign req_xfer    = req_i.valid && req_i.ready;

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.occurrences    = occ_q;
  assign rsp_o.first_position = first_q;

  // shared search step
  stocc_bound_step #(
    .CNT_W  (CNT_W),
    .ADDR_W (ADDR_W)
  ) u_step (
    .lo_i      (lo_q),
    .hi_i      (hi_q),
    .probe_i   (rdata_q),
    .key_i     (key_q),
    .strict_i  (strict_q),
    .done_o    (step_done),
    .mid_o     (step_mid),
    .lo_next_o (step_lo),
    .hi_next_o (step_hi)
  );

  // table memory: append write, registered probe read
  assign wr_en = req_xfer && (req_i.op == OP_APPEND) && (fill_q < DEPTH_C);
  assign rd_en = (state_q == S_PROBE) && !step_done;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[fill_q[ADDR_W-1:0]] <= req_i.value;
    end
    if (rd_en) begin
      rdata_q <= table_mem[step_mid];
    end
  end

  // count saturates at zero when the table is out of order
  assign count = (hi_q > lower_q) ? (hi_q - lower_q) : '0;

  // sequencer
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    lower_d     = lower_q;
    strict_d    = strict_q;
    key_d       = key_q;
    rsp_valid_d = rsp_valid_q;
    occ_d       = occ_q;
    first_d     = first_q;

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_xfer) begin
          case (req_i.op)
            OP_CLEAR: begin
              fill_d = '0;
            end
            OP_APPEND: begin
              if (fill_q < DEPTH_C) begin
                fill_d = fill_q + {{(CNT_W-1){1'b0}}, 1'b1};
              end
            end
            OP_QUERY: begin
              key_d    = req_i.value;
              lo_d     = '0;
              hi_d     = fill_q;
              strict_d = 1'b0;
              state_d  = S_PROBE;
            end
            default: begin
            end
          endcase
        end
      end
      S_PROBE: begin
        if (step_done) begin
          if (!strict_q) begin
            // lower bound found, start the upper bound search
            lower_d  = hi_q;
            lo_d     = '0;
            hi_d     = fill_q;
            strict_d = 1'b1;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        lo_d    = step_lo;
        hi_d    = step_hi;
        state_d = S_PROBE;
      end
      S_DONE: begin
        // load the result once the output register is free
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          occ_d       = OUT_W'(count);
          first_d     = OUT_W'(lower_q);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      rsp_valid_q <= 1'b0;
      strict_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rsp_valid_q <= rsp_valid_d;
      strict_q    <= strict_d;
    end
  end

  // search and result payload
  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    lower_q <= lower_d;
    key_q   <= key_d;
    occ_q   <= occ_d;
    first_q <= first_d;
  end

  // checks
  `include "sorted_table_occurrence_count_unit_assert.svh"

  `STOCC_ASSERT_IMP(a_fill_in_range, 1'b1, fill_q <= DEPTH_C)
  `STOCC_ASSERT_IMP(a_cmp_range_open, state_q == S_CMP, lo_q < hi_q)
  `STOCC_ASSERT_IMP(a_bounds_in_fill, state_q == S_DONE, (lower_q <= fill_q) && (hi_q <= fill_q))
  `STOCC_ASSERT_NXT(a_query_starts, req_xfer && (req_i.op == OP_QUERY), state_q == S_PROBE)

endmodule
